>>> rtl/umrb_pkg.sv
// umrb_pkg: shared constants for the usable memory run builder
// no dependencies; imported by umrb_trim and usable_memory_run_builder_top
`timescale 1ns / 1ps
`default_nettype none
package umrb_pkg;

    localparam int MAX_BANKS_DEF            = 8;
    localparam int MAX_RESERVED_REGIONS_DEF = 32;
    localparam int MAX_RUNS_DEF             = 32;
    localparam int PAGE_SHIFT_DEF           = 12;

    localparam int ADDR_W   = 64;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_BANK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RES_LEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RES_END  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd3;

    // summary status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_BANK  = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;

endpackage
`default_nettype wire

>>> rtl/usable_memory_run_builder_top.sv
// usable_memory_run_builder_top: collects banks and reserved regions, then
// subtracts, page-trims and emits the usable runs; uses umrb_pkg, umrb_trim
// load beats go in one per cycle with no result; a finish beat reads every run
// once per reserved region, then reads the runs left in a count pass and an emit
// pass, bounded by the single read port of the run memory, and waits on output stalls
// throughput: one finish in flight, input stalls until its summary; reset clears
// counters, sticky error and output valid, memories hold junk
`timescale 1ns / 1ps
`default_nettype none
module usable_memory_run_builder_top #(
    parameter int MAX_BANKS            = umrb_pkg::MAX_BANKS_DEF,
    parameter int MAX_RESERVED_REGIONS = umrb_pkg::MAX_RESERVED_REGIONS_DEF,
    parameter int MAX_RUNS             = umrb_pkg::MAX_RUNS_DEF,
    parameter int PAGE_SHIFT           = umrb_pkg::PAGE_SHIFT_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // input channel
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [umrb_pkg::KIND_W-1:0]    kind,
    input  wire  umrb_pkg::addr_t          region_base,
    input  wire  umrb_pkg::addr_t          region_extent,
    // result channel
    output logic                           out_valid,
    input  wire                            out_stall,
    output umrb_pkg::addr_t                run_base,
    output umrb_pkg::addr_t                run_size,
    output umrb_pkg::addr_t                bank_bytes,
    output umrb_pkg::addr_t                free_bytes,
    output logic [umrb_pkg::STATUS_W-1:0]  status,
    output logic                           is_summary,
    output logic                           last
);
    import umrb_pkg::*;

    // working list holds at most twice the run limit; one half of the run
    // memory must also fit every bank
    localparam int WCAP   = 2 * MAX_RUNS;
    localparam int HD     = (MAX_BANKS > WCAP) ? MAX_BANKS : WCAP;
    localparam int IW     = $clog2(HD);
    localparam int CW     = IW + 1;
    localparam int RIW    = (MAX_RESERVED_REGIONS > 1) ? $clog2(MAX_RESERVED_REGIONS) : 1;
    localparam int RCW    = $clog2(MAX_RESERVED_REGIONS + 1);
    localparam int UCW    = $clog2(MAX_RUNS + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RES  = 4'd1;
    localparam logic [3:0] S_WRD  = 4'd2;
    localparam logic [3:0] S_WCMP = 4'd3;
    localparam logic [3:0] S_WR2  = 4'd4;
    localparam logic [3:0] S_CRD  = 4'd5;
    localparam logic [3:0] S_CCHK = 4'd6;
    localparam logic [3:0] S_ERD  = 4'd7;
    localparam logic [3:0] S_EOUT = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;

    // memories: each entry is {start, end}, end wrapping modulo 2^64
    logic [2*ADDR_W-1:0] run_mem [2**(IW+1)];
    logic [2*ADDR_W-1:0] res_mem [2**RIW];

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       bank_count_reg, bank_count_next;
    logic [RCW-1:0]      res_count_reg, res_count_next;
    addr_t               total_reg, total_next;
    logic [STATUS_W-1:0] sticky_reg, sticky_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       nw_reg, nw_next;
    logic [CW-1:0]       nn_reg, nn_next;
    logic [RCW-1:0]      r_reg, r_next;
    logic                half_reg, half_next;
    logic [UCW-1:0]      cnt_reg, cnt_next;
    addr_t               usable_reg, usable_next;

    // memory ports
    logic                run_we, run_re, res_we, res_re;
    logic [IW:0]         run_waddr, run_raddr;
    logic [2*ADDR_W-1:0] run_wdata, res_wdata;
    logic [2*ADDR_W-1:0] run_q, res_q;

    // output register
    logic                out_valid_reg, out_valid_next;
    addr_t               o_base_reg, o_base_next;
    addr_t               o_size_reg, o_size_next;
    addr_t               o_total_reg, o_total_next;
    addr_t               o_usable_reg, o_usable_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic                o_summ_reg, o_summ_next;

    logic                in_acc, out_free;
    addr_t               bl, bh, rl, rh;
    logic                disjoint, has_head, has_tail;
    addr_t               p_lo, p_hi;
    addr_t               t_base, t_size;
    logic                t_ok;

    assign bl = run_q[2*ADDR_W-1:ADDR_W];
    assign bh = run_q[ADDR_W-1:0];
    assign rl = res_q[2*ADDR_W-1:ADDR_W];
    assign rh = res_q[ADDR_W-1:0];

    // page trim of the run just read
    umrb_trim #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_trim (
        .run_lo    (bl),
        .run_hi    (bh),
        .trim_base (t_base),
        .trim_size (t_size),
        .trim_ok   (t_ok)
    );

    // cut of one run by the current reserved region
    always_comb
    begin
        disjoint = (rh <= bl) || (rl >= bh);
        has_head = rl > bl;
        has_tail = rh < bh;
        p_lo     = bl;
        p_hi     = bh;
        if (!disjoint)
        begin
            if (has_head)
            begin
                p_hi = rl;
            end
            else
            begin
                p_lo = rh;
            end
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        bank_count_next = bank_count_reg;
        res_count_next  = res_count_reg;
        total_next      = total_reg;
        sticky_next     = sticky_reg;
        stat_next       = stat_reg;
        i_next          = i_reg;
        nw_next         = nw_reg;
        nn_next         = nn_reg;
        r_next          = r_reg;
        half_next       = half_reg;
        cnt_next        = cnt_reg;
        usable_next     = usable_reg;

        run_we    = 1'b0;
        run_waddr = {1'b0, bank_count_reg[IW-1:0]};
        run_wdata = {region_base, region_base + region_extent};
        run_re    = 1'b0;
        run_raddr = {half_reg, i_reg[IW-1:0]};
        res_we    = 1'b0;
        res_wdata = {region_base, region_base + region_extent};
        res_re    = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        o_base_next    = o_base_reg;
        o_size_next    = o_size_reg;
        o_total_next   = o_total_reg;
        o_usable_next  = o_usable_reg;
        o_status_next  = o_status_reg;
        o_summ_next    = o_summ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind)
                        KIND_BANK:
                        begin
                            if (bank_count_reg >= CW'(MAX_BANKS))
                            begin
                                if (sticky_reg == STATUS_OK)
                                    sticky_next = STATUS_CAPACITY;
                            end
                            else
                            begin
                                run_we          = 1'b1;
                                bank_count_next = bank_count_reg + 1'b1;
                                total_next      = total_reg + region_extent;
                            end
                        end
                        KIND_RES_LEN, KIND_RES_END:
                        begin
                            if (kind == KIND_RES_END)
                                res_wdata = {region_base, region_extent};
                            if ((kind == KIND_RES_LEN) ? (region_extent != '0)
                                                       : (region_extent > region_base))
                            begin
                                if (res_count_reg >= RCW'(MAX_RESERVED_REGIONS))
                                begin
                                    if (sticky_reg == STATUS_OK)
                                        sticky_next = STATUS_CAPACITY;
                                end
                                else
                                begin
                                    res_we         = 1'b1;
                                    res_count_next = res_count_reg + 1'b1;
                                end
                            end
                        end
                        KIND_FINISH:
                        begin
                            i_next      = '0;
                            nn_next     = '0;
                            r_next      = '0;
                            half_next   = 1'b0;
                            nw_next     = bank_count_reg;
                            cnt_next    = '0;
                            usable_next = '0;
                            stat_next   = STATUS_OK;
                            priority if (bank_count_reg == '0)
                            begin
                                stat_next  = STATUS_NO_BANK;
                                state_next = S_SUM;
                            end
                            else if (sticky_reg != STATUS_OK ||
                                     bank_count_reg > CW'(WCAP))
                            begin
                                stat_next  = STATUS_CAPACITY;
                                state_next = S_SUM;
                            end
                            else if (res_count_reg == '0)
                            begin
                                state_next = S_CRD;
                            end
                            else
                            begin
                                state_next = S_RES;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RES:
            begin
                res_re     = 1'b1;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                if (i_reg < nw_reg)
                begin
                    run_re     = 1'b1;
                    state_next = S_WCMP;
                end
                else
                begin
                    // pass over: the new list becomes the source
                    nw_next   = nn_reg;
                    nn_next   = '0;
                    i_next    = '0;
                    half_next = !half_reg;
                    r_next    = r_reg + 1'b1;
                    if (r_reg + 1'b1 < res_count_reg)
                        state_next = S_RES;
                    else
                        state_next = S_CRD;
                end
            end
            S_WCMP:
            begin
                run_waddr = {!half_reg, nn_reg[IW-1:0]};
                run_wdata = {p_lo, p_hi};
                if (disjoint || has_head || has_tail)
                begin
                    if (nn_reg >= CW'(WCAP))
                    begin
                        stat_next  = STATUS_CAPACITY;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        run_we  = 1'b1;
                        nn_next = nn_reg + 1'b1;
                        if (!disjoint && has_head && has_tail)
                        begin
                            state_next = S_WR2;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_WRD;
                        end
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_WR2:
            begin
                // tail piece of a split run
                run_waddr = {!half_reg, nn_reg[IW-1:0]};
                run_wdata = {rh, bh};
                if (nn_reg >= CW'(WCAP))
                begin
                    stat_next  = STATUS_CAPACITY;
                    state_next = S_SUM;
                end
                else
                begin
                    run_we     = 1'b1;
                    nn_next    = nn_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_CRD:
            begin
                if (i_reg < nw_reg)
                begin
                    run_re     = 1'b1;
                    state_next = S_CCHK;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_ERD;
                end
            end
            S_CCHK:
            begin
                state_next = S_CRD;
                i_next     = i_reg + 1'b1;
                if (t_ok)
                begin
                    if (cnt_reg >= UCW'(MAX_RUNS))
                    begin
                        stat_next  = STATUS_CAPACITY;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        cnt_next    = cnt_reg + 1'b1;
                        usable_next = usable_reg + t_size;
                    end
                end
            end
            S_ERD:
            begin
                if (i_reg < nw_reg)
                begin
                    run_re     = 1'b1;
                    state_next = S_EOUT;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_EOUT:
            begin
                if (!t_ok)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ERD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_base_next    = t_base;
                    o_size_next    = t_size;
                    o_total_next   = '0;
                    o_usable_next  = '0;
                    o_status_next  = STATUS_OK;
                    o_summ_next    = 1'b0;
                    i_next         = i_reg + 1'b1;
                    state_next     = S_ERD;
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    o_base_next     = '0;
                    o_size_next     = '0;
                    o_total_next    = (stat_reg == STATUS_OK) ? total_reg : '0;
                    o_usable_next   = (stat_reg == STATUS_OK) ? usable_reg : '0;
                    o_status_next   = stat_reg;
                    o_summ_next     = 1'b1;
                    // back to the empty collection state
                    bank_count_next = '0;
                    res_count_next  = '0;
                    total_next      = '0;
                    sticky_next     = STATUS_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // run memory: banks in half 0, subtraction ping-pongs between halves
    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[run_waddr] <= run_wdata;
        if (run_re)
            run_q <= run_mem[run_raddr];
    end

    // reserved region memory
    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_count_reg[RIW-1:0]] <= res_wdata;
        if (res_re)
            res_q <= res_mem[r_reg[RIW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bank_count_reg <= '0;
            res_count_reg  <= '0;
            total_reg      <= '0;
            sticky_reg     <= STATUS_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_count_reg <= bank_count_next;
            res_count_reg  <= res_count_next;
            total_reg      <= total_next;
            sticky_reg     <= sticky_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working counters and output payload
    always_ff @(posedge clk)
    begin
        stat_reg     <= stat_next;
        i_reg        <= i_next;
        nw_reg       <= nw_next;
        nn_reg       <= nn_next;
        r_reg        <= r_next;
        half_reg     <= half_next;
        cnt_reg      <= cnt_next;
        usable_reg   <= usable_next;
        o_base_reg   <= o_base_next;
        o_size_reg   <= o_size_next;
        o_total_reg  <= o_total_next;
        o_usable_reg <= o_usable_next;
        o_status_reg <= o_status_next;
        o_summ_reg   <= o_summ_next;
    end

    assign out_valid    = out_valid_reg;
    assign run_base     = o_base_reg;
    assign run_size     = o_size_reg;
    assign bank_bytes   = o_total_reg;
    assign free_bytes   = o_usable_reg;
    assign status       = o_status_reg;
    assign is_summary   = o_summ_reg;
    assign last         = o_summ_reg;

endmodule
`default_nettype wire

>>> rtl/umrb_trim.sv
// umrb_trim: shrinks one run inward to page boundaries
// depends on umrb_pkg
`timescale 1ns / 1ps
`default_nettype none
module umrb_trim #(
    parameter int PAGE_SHIFT = umrb_pkg::PAGE_SHIFT_DEF
) (
    input  wire umrb_pkg::addr_t run_lo,
    input  wire umrb_pkg::addr_t run_hi,
    output umrb_pkg::addr_t      trim_base,
    output umrb_pkg::addr_t      trim_size,
    output logic                 trim_ok
);
    import umrb_pkg::*;

    localparam addr_t PAGE_M1 = (addr_t'(1) << PAGE_SHIFT) - addr_t'(1);

    addr_t lo;
    addr_t hi;

    always_comb
    begin
        lo        = (run_lo + PAGE_M1) & ~PAGE_M1;
        hi        = run_hi & ~PAGE_M1;
        trim_ok   = hi > lo;
        trim_base = lo;
        trim_size = hi - lo;
    end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for usable_memory_run_builder_top
// depends on rtl/umrb_pkg.sv and rtl/usable_memory_run_builder_top.sv
`timescale 1ns / 1ps
module testbench;
    import umrb_pkg::*;

    localparam int   WORK_CAP   = 2 * MAX_RUNS_DEF;
    localparam addr_t PAGE      = addr_t'(1) << PAGE_SHIFT_DEF;
    localparam int   IDLE_LIMIT = 40000;

    // one load or finish beat as queued for the driver
    typedef struct {
        logic [KIND_W-1:0] k;
        addr_t             a;
        addr_t             b;
        bit                drain;   // hold back until all results are in
    } beat_t;

    // one result beat as predicted
    typedef struct {
        addr_t                base;
        addr_t                size;
        addr_t                total;
        addr_t                usable;
        logic [STATUS_W-1:0]  st;
        logic                 summ;
    } run_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = KIND_BANK;
    addr_t                 region_base = '0;
    addr_t                 region_extent = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    addr_t                 run_base;
    addr_t                 run_size;
    addr_t                 bank_bytes;
    addr_t                 free_bytes;
    logic [STATUS_W-1:0]   status;
    logic                  is_summary;
    logic                  last;

    beat_t       pending_beats[$];
    run_item_t   expected_runs[$];
    beat_t       cur_beat;
    int          errors = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          beats_in = 0;
    int          runs_out = 0;
    int          summaries = 0;
    int          error_summaries = 0;
    bit          quiet = 1'b0;

    // predictor state: what the block has collected so far
    addr_t              bank_lo[MAX_BANKS_DEF];
    addr_t              bank_len[MAX_BANKS_DEF];
    int                 nbank = 0;
    addr_t              resv_lo[MAX_RESERVED_REGIONS_DEF];
    addr_t              resv_len[MAX_RESERVED_REGIONS_DEF];
    int                 nresv = 0;
    addr_t              bank_total = '0;
    logic [STATUS_W-1:0] first_err = STATUS_OK;

    usable_memory_run_builder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .region_base   (region_base),
        .region_extent (region_extent),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .run_base      (run_base),
        .run_size      (run_size),
        .bank_bytes    (bank_bytes),
        .free_bytes    (free_bytes),
        .status        (status),
        .is_summary    (is_summary),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_reserved(addr_t lo, addr_t len);
        if (len == 0)
            return;
        if (nresv >= MAX_RESERVED_REGIONS_DEF)
        begin
            if (first_err == STATUS_OK)
                first_err = STATUS_CAPACITY;
            return;
        end
        resv_lo[nresv]  = lo;
        resv_len[nresv] = len;
        nresv++;
    endfunction

    function automatic void push_piece(ref addr_t qb[$], ref addr_t qs[$],
                                       input addr_t b, input addr_t s,
                                       ref logic [STATUS_W-1:0] st);
        if (qb.size() >= WORK_CAP)
            st = STATUS_CAPACITY;
        else
        begin
            qb.push_back(b);
            qs.push_back(s);
        end
    endfunction

    // subtract, trim and queue the results of a finish beat
    function automatic void build_usable_runs();
        addr_t               mask;
        logic [STATUS_W-1:0] st;
        addr_t               wb[$], ws[$], sb[$], ss[$];
        addr_t               rl, rh, bl, bh, lo, hi, usable;
        run_item_t           runs[$];
        run_item_t           it;
        mask   = ~(PAGE - 1);
        usable = '0;
        if (nbank == 0)
            st = STATUS_NO_BANK;
        else if (first_err != STATUS_OK)
            st = STATUS_CAPACITY;
        else
            st = STATUS_OK;
        if (st == STATUS_OK)
            for (int i = 0; i < nbank; i++)
            begin
                wb.push_back(bank_lo[i]);
                ws.push_back(bank_len[i]);
            end
        for (int r = 0; st == STATUS_OK && r < nresv; r++)
        begin
            rl = resv_lo[r];
            rh = rl + resv_len[r];
            sb = {};
            ss = {};
            for (int i = 0; st == STATUS_OK && i < wb.size(); i++)
            begin
                bl = wb[i];
                bh = bl + ws[i];
                if (rh <= bl || rl >= bh)
                    push_piece(sb, ss, bl, ws[i], st);
                else
                begin
                    if (rl > bl)
                        push_piece(sb, ss, bl, rl - bl, st);
                    if (rh < bh && st == STATUS_OK)
                        push_piece(sb, ss, rh, bh - rh, st);
                end
            end
            if (st == STATUS_OK)
            begin
                wb = sb;
                ws = ss;
            end
        end
        for (int i = 0; st == STATUS_OK && i < wb.size(); i++)
        begin
            lo = (wb[i] + PAGE - 1) & mask;
            hi = (wb[i] + ws[i]) & mask;
            if (hi <= lo)
                continue;
            if (runs.size() >= MAX_RUNS_DEF)
                st = STATUS_CAPACITY;
            else
            begin
                it = '{lo, hi - lo, '0, '0, STATUS_OK, 1'b0};
                runs.push_back(it);
                usable += hi - lo;
            end
        end
        if (st != STATUS_OK)
            expected_runs.push_back('{'0, '0, '0, '0, st, 1'b1});
        else
        begin
            foreach (runs[i])
                expected_runs.push_back(runs[i]);
            expected_runs.push_back('{'0, '0, bank_total, usable, STATUS_OK, 1'b1});
        end
        nbank      = 0;
        nresv      = 0;
        bank_total = '0;
        first_err  = STATUS_OK;
    endfunction

    function automatic void absorb_beat(beat_t bt);
        case (bt.k)
            KIND_BANK:
                if (nbank >= MAX_BANKS_DEF)
                begin
                    if (first_err == STATUS_OK)
                        first_err = STATUS_CAPACITY;
                end
                else
                begin
                    bank_lo[nbank]  = bt.a;
                    bank_len[nbank] = bt.b;
                    nbank++;
                    bank_total += bt.b;
                end
            KIND_RES_LEN:
                note_reserved(bt.a, bt.b);
            KIND_RES_END:
                if (bt.b > bt.a)
                    note_reserved(bt.a, bt.b - bt.a);
            default:
                build_usable_runs();
        endcase
    endfunction

    function automatic addr_t rand64();
        return {$urandom, $urandom};
    endfunction

    // addresses clustered in one window so regions overlap the banks
    function automatic addr_t window_addr();
        addr_t x;
        x = 64'h8000_0000 + addr_t'($urandom_range(0, 255)) * 64'h800;
        if ($urandom_range(0, 3) == 0)
            x += addr_t'($urandom_range(0, 4095));
        return x;
    endfunction

    function automatic void queue_beat(logic [KIND_W-1:0] k, addr_t a, addr_t b,
                                       bit drain = 1'b0);
        beat_t bt;
        bt = '{k, a, b, drain};
        pending_beats.push_back(bt);
    endfunction

    function automatic void queue_finish(bit drain = 1'b0);
        queue_beat(KIND_FINISH, rand64(), rand64(), drain);
    endfunction

    // driver: one beat from the queue, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_beat(cur_beat);
                beats_in++;
            end
            quiet = pending_beats.size() < 25;
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 &&
                         (!pending_beats[0].drain || expected_runs.size() == 0))
                begin
                    if (!quiet && $urandom_range(0, 5) == 0)
                    begin
                        gap_left = $urandom_range(1, 13) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        cur_beat = pending_beats.pop_front();
                        in_valid      <= 1'b1;
                        kind          <= cur_beat.k;
                        region_base   <= cur_beat.a;
                        region_extent <= cur_beat.b;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, addr_t want, addr_t got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        run_item_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual base %h size %h status %0d",
                             $time, run_base, run_size, status);
                    errors++;
                end
                else
                begin
                    e = expected_runs.pop_front();
                    check_field("run_base", e.base, run_base);
                    check_field("run_size", e.size, run_size);
                    check_field("bank_bytes", e.total, bank_bytes);
                    check_field("free_bytes", e.usable, free_bytes);
                    check_field("status", addr_t'(e.st), addr_t'(status));
                    check_field("is_summary", addr_t'(e.summ), addr_t'(is_summary));
                    check_field("last", addr_t'(e.summ), addr_t'(last));
                    if (e.summ)
                    begin
                        summaries++;
                        if (e.st != STATUS_OK)
                            error_summaries++;
                    end
                    else
                        runs_out++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int nb, nr, mode;
        addr_t lo;

        // finish with no bank at all, then no bank but a reserved region
        queue_beat(KIND_FINISH, '1, '1);
        queue_beat(KIND_RES_LEN, 64'h1000, 64'h2000);
        queue_finish();

        // one bank; zero-length regions skipped; a mid split and a head cut
        queue_beat(KIND_BANK, 64'h1000_0000, 64'h1000_0000);
        queue_beat(KIND_RES_LEN, 64'h1400_0000, 64'h0);
        queue_beat(KIND_RES_END, 64'h1500_0000, 64'h1500_0000);
        queue_beat(KIND_RES_END, 64'h1600_0000, 64'h1500_0000);
        queue_beat(KIND_RES_LEN, 64'h1800_0000, 64'h1000);
        queue_beat(KIND_RES_END, 64'h0, 64'h1000_0800);
        queue_finish(1'b1);

        // extremes: wrapping bank at the top, full-range bank, unaligned and empty banks
        queue_beat(KIND_BANK, 64'hFFFF_FFFF_FFFF_F000, 64'h2000);
        queue_beat(KIND_BANK, 64'h0, '1);
        queue_beat(KIND_BANK, 64'h123, 64'h1FFF);
        queue_beat(KIND_BANK, 64'h5000, 64'h0);
        queue_beat(KIND_RES_END, 64'hFFFF_FFFF_0000_0000, '1);
        queue_beat(KIND_RES_LEN, '1, '1);
        queue_finish();

        // bank overflow: nine banks
        for (int i = 0; i < 9; i++)
            queue_beat(KIND_BANK, 64'h1_0000_0000 * i, 64'h10_0000);
        queue_finish(1'b1);

        // too many usable runs: one bank cut by 32 tiny regions
        queue_beat(KIND_BANK, 64'h4000_0000, 64'h100_0000);
        for (int i = 0; i < 32; i++)
            queue_beat(KIND_RES_LEN, 64'h4000_0000 + (i + 1) * 64'h4000, 64'h100);
        queue_finish();

        // reserved overflow: 33 regions after one bank
        queue_beat(KIND_BANK, 64'h2000_0000, 64'h10_0000);
        for (int i = 0; i < 33; i++)
            queue_beat(KIND_RES_END, 64'h2000_0000 + i * 64'h8000,
                       64'h2000_0000 + i * 64'h8000 + 64'h1800);
        queue_finish();

        // random sequences, mostly well formed
        while (pending_beats.size() < 130)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                nb = $urandom_range(1, 6);
                for (int i = 0; i < nb; i++)
                    queue_beat(KIND_W'($urandom_range(0, 2)), rand64(), rand64());
            end
            else
            begin
                nb = (mode == 1) ? $urandom_range(8, 10) : $urandom_range(0, 4);
                nr = $urandom_range(0, 6);
                for (int i = 0; i < nb; i++)
                    queue_beat(KIND_BANK, window_addr(),
                               addr_t'($urandom_range(0, 64)) * 64'h1000
                               + addr_t'($urandom_range(0, 1) * $urandom_range(0, 4095)));
                for (int i = 0; i < nr; i++)
                begin
                    lo = window_addr();
                    if ($urandom_range(0, 1) == 0)
                        queue_beat(KIND_RES_LEN, lo, addr_t'($urandom_range(0, 65536)));
                    else
                        queue_beat(KIND_RES_END, lo, lo + addr_t'($urandom_range(0, 65536))
                                   - addr_t'($urandom_range(0, 4096)));
                end
            end
            queue_finish($urandom_range(0, 3) == 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (expected_runs.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time, expected_runs.size());
            errors++;
        end

        $display("run covered %0d input beats, %0d usable runs and %0d summaries",
                 beats_in, runs_out, summaries);
        $display("of which %0d summaries reported an error status", error_summaries);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
